// ===== sv/rbe_pkg.sv =====
// Shared types, register codes and byte functions for the Rijndael block encryptor.
// Used by rbe_round, rijndael_block_encrypt_top and the testbench; no dependencies.
package rbe_pkg;

   localparam int MaxColumns = 8;
   localparam int MaxRounds  = 14;
   localparam int MaxBytes   = 4 * MaxColumns;
   localparam int KeyRows    = MaxRounds + 1;

   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_NB   = 3'd4;
   localparam logic [2:0] CSR_NK   = 3'd5;
   localparam logic [2:0] CSR_NR   = 3'd6;

   localparam logic [7:0] RconPoly = 8'h1b;

   typedef struct packed {
      logic        func;
      logic [3:0]  round_index;
      logic [63:0] block_word0;
      logic [63:0] block_word1;
      logic [63:0] block_word2;
      logic [63:0] block_word3;
   } req_type;

   typedef struct packed {
      logic [63:0] out_word0;
      logic [63:0] out_word1;
      logic [63:0] out_word2;
      logic [63:0] out_word3;
      logic [63:0] sbox_word0;
      logic [63:0] sbox_word1;
      logic [63:0] sbox_word2;
      logic [63:0] sbox_word3;
   } rsp_type;

   typedef logic [MaxBytes-1:0][7:0]     state_type;
   typedef logic [MaxColumns-1:0][31:0]  row_type;
   typedef logic [3:0][63:0]             words_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] gmul2(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? RconPoly : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // Byte i sits in word i/8, byte 0 of a word in its top bits.
   function automatic state_type unpack(input words_type w);
      state_type s;
      for (int i = 0; i < MaxBytes; i++) begin
         s[i] = w[i / 8][63 - 8 * (i % 8) -: 8];
      end
      return s;
   endfunction

   // Drop bytes beyond the active block width.
   function automatic words_type pack(input state_type s, input logic [3:0] nb);
      words_type w;
      for (int i = 0; i < MaxBytes; i++) begin
         w[i / 8][63 - 8 * (i % 8) -: 8] = (6'(i) < {nb, 2'b00}) ? s[i] : 8'h00;
      end
      return w;
   endfunction

endpackage

// ===== sv/rbe_round.sv =====
// One Rijndael round (SubBytes, ShiftRows, optional MixColumns) plus round key addition, or the key addition alone.
// Depends on rbe_pkg.
module rbe_round (
   input  rbe_pkg::state_type state,
   input  rbe_pkg::row_type   rkey,
   input  logic [3:0]         nb,
   input  logic               do_round,
   input  logic               do_mix,
   output rbe_pkg::state_type sub_state,
   output rbe_pkg::state_type next_state
);
   import rbe_pkg::*;

   state_type shifted;
   state_type mixed;
   state_type pre_key;

   always_comb begin
      logic [3:0] src;
      logic [7:0] a0, a1, a2, a3, t;
      for (int i = 0; i < MaxBytes; i++) begin
         sub_state[i] = SBOX[state[i]];
      end
      // Row r rotates left by r columns, modulo the active width.
      for (int c = 0; c < MaxColumns; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = 4'(c + r);
            if (src >= nb) begin
               src = src - nb;
            end
            shifted[4 * c + r] = sub_state[{src[2:0], 2'(r)}];
         end
      end
      for (int c = 0; c < MaxColumns; c++) begin
         a0 = shifted[4 * c];
         a1 = shifted[4 * c + 1];
         a2 = shifted[4 * c + 2];
         a3 = shifted[4 * c + 3];
         t  = a0 ^ a1 ^ a2 ^ a3;
         mixed[4 * c]     = a0 ^ t ^ gmul2(a0 ^ a1);
         mixed[4 * c + 1] = a1 ^ t ^ gmul2(a1 ^ a2);
         mixed[4 * c + 2] = a2 ^ t ^ gmul2(a2 ^ a3);
         mixed[4 * c + 3] = a3 ^ t ^ gmul2(a3 ^ a0);
      end
      if (!do_round) begin
         pre_key = state;
      end else if (do_mix) begin
         pre_key = mixed;
      end else begin
         pre_key = shifted;
      end
      for (int c = 0; c < MaxColumns; c++) begin
         for (int b = 0; b < 4; b++) begin
            next_state[4 * c + b] = pre_key[4 * c + b] ^ rkey[c][31 - 8 * b -: 8];
         end
      end
   end

endmodule

// ===== sv/rijndael_block_encrypt_top.sv =====
// Rijndael encryptor top: registers, key schedule sequencer, round key memory, round control.
// Depends on rbe_pkg and rbe_round.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | rbe_pkg::req_type (func, round, block)
//   rsp_    | out       | rsp_valid / rsp_ready | rbe_pkg::rsp_type (result, SubBytes state)
//   csr_    | in        | csr_valid / csr_ready | csr_index (3b), csr_data (64b)
//
// A request passes from acceptance through S_LOAD, S_RUN and S_DONE; whole-block encryption
// stays in S_RUN for rounds 0 to num_rounds, a single round visits it once. rsp_valid rises
// as the block returns to S_IDLE, where it takes the next request; no request is taken while
// one is in flight. The round loop reads one 256-bit round key row per cycle from the key
// memory, so the memory read port sets the pace of one round per cycle.
// After reset or any register write, the first request first runs the key schedule:
// one key word per cycle, block_columns * (num_rounds + 1) words (at most 120).
// Reset is synchronous; the key memory itself is not cleared. A result waiting on
// rsp_ready does not block acceptance of the next request, but holds it in S_DONE.
module rijndael_block_encrypt_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbe_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_data
);
   import rbe_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXPAND = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_RUN    = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   // Configuration registers
   logic [3:0][63:0] key_ff;
   logic [3:0]       nb_raw_ff, nk_raw_ff, nr_raw_ff;
   logic             sched_ready_ff, sched_ready_in;
   logic [3:0]       nb, nk, nr;

   // Control
   logic [2:0]  state_ff, state_in;
   logic        func_ff;
   logic [3:0]  rnd_ff, rnd_in;
   logic [3:0]  rsel_ff;
   state_type   st_ff, st_in;
   state_type   sb_ff, sb_in;

   // Key schedule
   logic [6:0]  ki_ff, ki_in;
   logic [2:0]  col_ff, col_in;
   logic [3:0]  krow_ff, krow_in;
   logic [2:0]  kmod_ff, kmod_in;
   logic        first_ff, first_in;
   logic [7:0]  rcon_ff, rcon_in;
   row_type     win_ff, win_in;
   row_type     row_ff, row_in;
   logic [31:0] kword;
   logic [6:0]  ktotal;

   // Key memory: one row of round key per round
   row_type     key_mem [KeyRows];
   row_type     krd_ff;
   logic        kwe;
   logic [3:0]  kwaddr;
   logic        kre;
   logic [3:0]  kraddr;

   // Output register
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // Round datapath
   state_type   rnd_sub, rnd_next;
   logic        do_round, do_mix;
   words_type   out_w, sb_w;
   logic        accept;

   assign nb = (nb_raw_ff < 4'd4) ? 4'd4 : (nb_raw_ff > 4'(MaxColumns)) ? 4'(MaxColumns) : nb_raw_ff;
   assign nk = (nk_raw_ff < 4'd4) ? 4'd4 : (nk_raw_ff > 4'(MaxColumns)) ? 4'(MaxColumns) : nk_raw_ff;
   assign nr = (nr_raw_ff < 4'd10) ? 4'd10 : (nr_raw_ff > 4'(MaxRounds)) ? 4'(MaxRounds) : nr_raw_ff;

   assign ktotal    = 7'({3'b000, nb} * ({3'b000, nr} + 7'd1));
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next schedule word: key words first, then the Rijndael recurrence.
   always_comb begin
      logic [31:0] t;
      t = win_ff[0];
      rcon_in = rcon_ff;
      if (first_ff) begin
         kword = key_ff[kmod_ff[2:1]][63 - 32 * 32'(kmod_ff[0]) -: 32];
      end else begin
         if (kmod_ff == 3'd0) begin
            t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
            rcon_in = gmul2(rcon_ff);
         end else if (nk > 4'd6 && kmod_ff == 3'd4) begin
            t = sub_word(t);
         end
         kword = win_ff[3'(nk - 4'd1)] ^ t;
      end
   end

   always_comb begin
      win_in = {win_ff[MaxColumns-2:0], kword};
      row_in = row_ff;
      row_in[col_ff] = kword;
      kwe    = (state_ff == S_EXPAND) && (col_ff == 3'(nb - 4'd1));
      kwaddr = krow_ff;
   end

   assign do_round = func_ff || (rnd_ff != 4'd0);
   assign do_mix   = (rnd_ff != nr);

   rbe_round u_round (
      .state      (st_ff),
      .rkey       (krd_ff),
      .nb         (nb),
      .do_round   (do_round),
      .do_mix     (do_mix),
      .sub_state  (rnd_sub),
      .next_state (rnd_next)
   );

   assign out_w = pack(st_ff, nb);
   assign sb_w  = pack(sb_ff, nb);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      rnd_in         = rnd_ff;
      st_in          = st_ff;
      sb_in          = sb_ff;
      sched_ready_in = sched_ready_ff;
      ki_in          = ki_ff;
      col_in         = col_ff;
      krow_in        = krow_ff;
      kmod_in        = kmod_ff;
      first_in       = first_ff;
      kre            = 1'b0;
      kraddr         = rnd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               st_in    = unpack({req_data.block_word3, req_data.block_word2,
                                  req_data.block_word1, req_data.block_word0});
               sb_in    = '0;
               ki_in    = '0;
               col_in   = '0;
               krow_in  = '0;
               kmod_in  = '0;
               first_in = 1'b1;
               state_in = sched_ready_ff ? S_LOAD : S_EXPAND;
            end
         end
         S_EXPAND: begin
            ki_in = ki_ff + 7'd1;
            if (col_ff == 3'(nb - 4'd1)) begin
               col_in  = '0;
               krow_in = krow_ff + 4'd1;
            end else begin
               col_in = col_ff + 3'd1;
            end
            if (kmod_ff == 3'(nk - 4'd1)) begin
               kmod_in  = '0;
               first_in = 1'b0;
            end else begin
               kmod_in = kmod_ff + 3'd1;
            end
            if (ki_ff == ktotal - 7'd1) begin
               sched_ready_in = 1'b1;
               state_in       = S_LOAD;
            end
         end
         S_LOAD: begin
            // Fetch the first key row: row 0 for a block, the chosen round (capped at nr) otherwise.
            kre      = 1'b1;
            rnd_in   = func_ff ? ((rsel_ff > nr) ? nr : rsel_ff) : 4'd0;
            kraddr   = rnd_in;
            state_in = S_RUN;
         end
         S_RUN: begin
            st_in = rnd_next;
            if (func_ff) begin
               sb_in    = rnd_sub;
               state_in = S_DONE;
            end else if (rnd_ff == nr) begin
               state_in = S_DONE;
            end else begin
               kre    = 1'b1;
               rnd_in = rnd_ff + 4'd1;
               kraddr = rnd_in;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // Any register write invalidates the stored schedule.
      if (csr_valid && csr_index <= CSR_NR) begin
         sched_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         sched_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         key_ff         <= '0;
         nb_raw_ff      <= 4'd4;
         nk_raw_ff      <= 4'd4;
         nr_raw_ff      <= 4'd10;
      end else begin
         state_ff       <= state_in;
         sched_ready_ff <= sched_ready_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_KEY0: key_ff[0] <= csr_data;
               CSR_KEY1: key_ff[1] <= csr_data;
               CSR_KEY2: key_ff[2] <= csr_data;
               CSR_KEY3: key_ff[3] <= csr_data;
               CSR_NB:   nb_raw_ff <= csr_data[3:0];
               CSR_NK:   nk_raw_ff <= csr_data[3:0];
               CSR_NR:   nr_raw_ff <= csr_data[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers, no reset needed
   always_ff @(posedge clock) begin
      rnd_ff  <= rnd_in;
      st_ff   <= st_in;
      sb_ff   <= sb_in;
      ki_ff   <= ki_in;
      col_ff  <= col_in;
      krow_ff <= krow_in;
      kmod_ff <= kmod_in;
      first_ff <= first_in;
      if (state_ff == S_IDLE) begin
         rcon_ff <= 8'h01;
      end else if (state_ff == S_EXPAND) begin
         rcon_ff <= rcon_in;
      end
      if (state_ff == S_EXPAND) begin
         win_ff <= win_in;
         row_ff <= row_in;
      end
      if (accept) begin
         func_ff <= req_data.func;
         rsel_ff <= req_data.round_index;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff <= '{out_word0: out_w[0], out_word1: out_w[1],
                     out_word2: out_w[2], out_word3: out_w[3],
                     sbox_word0: sb_w[0], sbox_word1: sb_w[1],
                     sbox_word2: sb_w[2], sbox_word3: sb_w[3]};
      end
   end

   // Round key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (kwe) begin
         key_mem[kwaddr] <= row_in;
      end
      if (kre) begin
         krd_ff <= key_mem[kraddr];
      end
   end

`ifndef SYNTHESIS
   a_run_needs_schedule: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> sched_ready_ff)
      else $error("round loop running without a valid key schedule");
   a_write_only_expand: assert property (@(posedge clock) disable iff (reset)
      kwe |-> state_ff == S_EXPAND)
      else $error("key memory written outside the schedule pass");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted request did not start");
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      kre |-> kraddr <= nr)
      else $error("key row read beyond the last round");
`endif

endmodule

// ===== bench/testbench.sv =====
// Testbench for rijndael_block_encrypt_top: directed and random encryption requests
// checked against a behavioral Rijndael model kept in this file. Depends on rbe_pkg and the top.
`timescale 1ns / 100ps

module testbench;
   import rbe_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   rijndael_block_encrypt_top i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Model copy of the registers and the expanded key.
   logic [63:0] key_reg [4];
   logic [3:0]  nb_reg, nk_reg, nr_reg;
   logic [31:0] sched_words [120];
   bit          keys_valid;

   rsp_type     expected_results [$];
   int          mismatches, results_seen, requests_sent, rounds_sent, errors;

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic int clampi(input int v, input int lo, input int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [7:0] byte_of(input logic [3:0][63:0] w, input int i);
      return w[i / 8][63 - 8 * (i % 8) -: 8];
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic void build_schedule(input int nb, input int nk, input int nr);
      logic [3:0][63:0] kw;
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      kw = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
      for (int i = 0; i < nk; i++)
         sched_words[i] = {byte_of(kw, 4*i), byte_of(kw, 4*i+1),
                           byte_of(kw, 4*i+2), byte_of(kw, 4*i+3)};
      for (int i = nk; i < nb * (nr + 1) && i < 120; i++) begin
         t = sched_words[i-1];
         if (i % nk == 0) begin
            t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = xtime(rc);
         end else if (nk > 6 && i % nk == 4) begin
            t = sbox_word(t);
         end
         sched_words[i] = sched_words[i-nk] ^ t;
      end
   endfunction

   function automatic void add_round_key(ref logic [7:0] st [32], input int nb, input int r);
      logic [31:0] k;
      for (int c = 0; c < nb; c++) begin
         k = sched_words[(nb * r + c) % 120];
         for (int b = 0; b < 4; b++) st[4*c+b] ^= k[31 - 8*b -: 8];
      end
   endfunction

   function automatic void sub_shift(ref logic [7:0] st [32], input int nb,
                                     ref logic [7:0] sb [32]);
      logic [7:0] tmp [32];
      for (int i = 0; i < 4*nb; i++) st[i] = SBOX[st[i]];
      sb = st;
      for (int c = 0; c < nb; c++)
         for (int r = 0; r < 4; r++) tmp[4*c+r] = st[4*((c+r) % nb)+r];
      for (int i = 0; i < 4*nb; i++) st[i] = tmp[i];
   endfunction

   function automatic void mix(ref logic [7:0] st [32], input int nb);
      logic [7:0] a0, a1, a2, a3, t;
      for (int c = 0; c < nb; c++) begin
         a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
         t = a0 ^ a1 ^ a2 ^ a3;
         st[4*c]   = a0 ^ t ^ xtime(a0 ^ a1);
         st[4*c+1] = a1 ^ t ^ xtime(a1 ^ a2);
         st[4*c+2] = a2 ^ t ^ xtime(a2 ^ a3);
         st[4*c+3] = a3 ^ t ^ xtime(a3 ^ a0);
      end
   endfunction

   function automatic logic [255:0] pack_state(input logic [7:0] st [32], input int nb);
      logic [3:0][63:0] w;
      w = '0;
      for (int i = 0; i < 4*nb; i++) w[i / 8][63 - 8 * (i % 8) -: 8] = st[i];
      return {w[0], w[1], w[2], w[3]};
   endfunction

   // Compute the encrypted (or single-round) state for one request.
   function automatic rsp_type encrypt_block(input req_type rq);
      int nb, nk, nr, r;
      logic [7:0] st [32];
      logic [7:0] sb [32];
      logic [3:0][63:0] in_w;
      rsp_type res;
      nb = clampi(nb_reg, 4, 8);
      nk = clampi(nk_reg, 4, 8);
      nr = clampi(nr_reg, 10, 14);
      if (!keys_valid) begin
         build_schedule(nb, nk, nr);
         keys_valid = 1'b1;
      end
      in_w = {rq.block_word3, rq.block_word2, rq.block_word1, rq.block_word0};
      for (int i = 0; i < 32; i++) begin
         st[i] = (i < 4*nb) ? byte_of(in_w, i) : 8'h00;
         sb[i] = 8'h00;
      end
      if (!rq.func) begin
         add_round_key(st, nb, 0);
         for (int k = 1; k < nr; k++) begin
            sub_shift(st, nb, sb);
            mix(st, nb);
            add_round_key(st, nb, k);
         end
         sub_shift(st, nb, sb);
         add_round_key(st, nb, nr);
         for (int i = 0; i < 32; i++) sb[i] = 8'h00;
      end else begin
         r = rq.round_index > nr ? nr : rq.round_index;
         sub_shift(st, nb, sb);
         if (r < nr) mix(st, nb);
         add_round_key(st, nb, r);
      end
      res = {pack_state(st, nb), pack_state(sb, nb)};
      return res;
   endfunction

   // Random gap: mostly none or short, occasionally long.
   function automatic int idle_gap();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Keep valid high across back-to-back requests; drop it only for a gap.
   task automatic send_request(input req_type rq);
      int gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      expected_results.push_back(encrypt_block(rq));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      if (rq.func) rounds_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx <= CSR_KEY3) key_reg[idx[1:0]] = value;
      else if (idx == CSR_NB) nb_reg = value[3:0];
      else if (idx == CSR_NK) nk_reg = value[3:0];
      else if (idx == CSR_NR) nr_reg = value[3:0];
      keys_valid = 1'b0;
   endtask

   task automatic set_geometry(input int nb, input int nk, input int nr);
      wait_drained();
      write_reg(CSR_NB, 64'(nb));
      write_reg(CSR_NK, 64'(nk));
      write_reg(CSR_NR, 64'(nr));
   endtask

   task automatic load_key(input logic [63:0] k0, k1, k2, k3);
      wait_drained();
      write_reg(CSR_KEY0, k0);
      write_reg(CSR_KEY1, k1);
      write_reg(CSR_KEY2, k2);
      write_reg(CSR_KEY3, k3);
   endtask

   function automatic req_type random_request();
      req_type rq;
      rq.func = 1'($urandom_range(1));
      rq.round_index = 4'($urandom_range(15));
      rq.block_word0 = {$urandom, $urandom};
      rq.block_word1 = {$urandom, $urandom};
      rq.block_word2 = {$urandom, $urandom};
      rq.block_word3 = {$urandom, $urandom};
      return rq;
   endfunction

   // Reset register values, all-zero and all-ones blocks, every round index.
   task automatic test_directed();
      req_type rq;
      rq = '0;
      send_request(rq);
      rq = '1; rq.func = 1'b0;
      send_request(rq);
      for (int r = 0; r < 16; r++) begin
         rq = random_request();
         rq.func = 1'b1;
         rq.round_index = 4'(r);
         send_request(rq);
      end
   endtask

   // Widths at the extremes, out-of-range values that saturate, all-ones key.
   task automatic test_extremes();
      req_type rq;
      load_key('1, '1, '1, '1);
      set_geometry(8, 8, 14);
      rq = '1; rq.func = 1'b0;
      send_request(rq);
      rq.func = 1'b1; rq.round_index = 4'd14;
      send_request(rq);
      set_geometry(15, 0, 15);
      send_request(random_request());
      set_geometry(0, 15, 0);
      send_request(random_request());
      send_request(random_request());
   endtask

   // Random requests under a series of random keys and geometries.
   task automatic test_random();
      for (int phase = 0; phase < 20; phase++) begin
         load_key({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
         if (phase % 4 == 0) set_geometry($urandom_range(15), $urandom_range(15),
                                           $urandom_range(15));
         else set_geometry($urandom_range(8, 4), $urandom_range(8, 4),
                           $urandom_range(14, 10));
         for (int n = 0; n < 50; n++) begin
            // Hold off until the pipeline is empty once per phase.
            if (n == 25) wait_drained();
            send_request(random_request());
         end
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type exp;
      results_seen++;
      if (expected_results.size() == 0) begin
         errors++;
         if (mismatches++ < 10) $display("unexpected result %h", got);
         return;
      end
      exp = expected_results.pop_front();
      if (got !== exp) begin
         errors++;
         if (mismatches++ < 10)
            $display("mismatch on result %0d\n  expected %h\n  actual   %h",
                     results_seen, exp, got);
      end
   endtask

   // Drive rsp_ready with random stalls, check each accepted result.
   initial begin
      int gap;
      forever begin
         gap = idle_gap();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
   end

   initial begin
      key_reg = '{default: '0};
      nb_reg = 4'd4; nk_reg = 4'd4; nr_reg = 4'd10;
      keys_valid = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_extremes();
      test_random();
      wait_drained();
      $display("Sent %0d requests (%0d single-round) over reset, extreme and random",
               requests_sent, rounds_sent);
      $display("key/geometry settings; checked %0d results, %0d mismatches.",
               results_seen, mismatches);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("TEST FAILED");
      $finish;
   end

endmodule
